// ===== hw/rtl/crcfr_pkg.sv =====
package crcfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned RELAY_W  = 6;
    localparam int unsigned VOLUME_W = 16;

    localparam logic [BYTE_W-1:0]  CRC_POLY  = 8'h31;
    localparam logic [BYTE_W-1:0]  CRC_INIT  = 8'hFF;
    localparam logic [BYTE_W-1:0]  CRC_TOP   = 8'h80;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_BAD_CRC = 2'd2
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [RELAY_W-1:0]    relays;
        logic [VOLUME_W-1:0]   volume;
    } t_frame_rec;

    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crcfr_front.sv =====
module crcfr_front #(
    parameter int FRAME_BYTES = 10,
    parameter int RELAY_COUNT = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [crcfr_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_last_byte,
    input  logic                                i_q_full,
    output logic                                o_rec_push,
    output crcfr_pkg::t_frame_rec               o_rec
);

    localparam logic [crcfr_pkg::COUNT_W-1:0] LEN_OK     = crcfr_pkg::COUNT_W'(FRAME_BYTES);
    localparam logic [crcfr_pkg::COUNT_W-1:0] RELAY_LAST = crcfr_pkg::COUNT_W'(RELAY_COUNT);
    localparam logic [crcfr_pkg::COUNT_W-1:0] VOL_LO_POS = crcfr_pkg::COUNT_W'(RELAY_COUNT + 1);
    localparam logic [crcfr_pkg::COUNT_W-1:0] VOL_HI_POS = crcfr_pkg::COUNT_W'(RELAY_COUNT + 2);
    localparam logic [crcfr_pkg::RELAY_W-1:0] RELAY_MASK =
        crcfr_pkg::RELAY_W'((1 << RELAY_COUNT) - 1);

    logic [crcfr_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [crcfr_pkg::BYTE_W-1:0]   r_crc, n_crc;
    logic [crcfr_pkg::RELAY_W-1:0]  r_staged_relays, n_staged_relays;
    logic [crcfr_pkg::VOLUME_W-1:0] r_staged_volume, n_staged_volume;
    logic                           accept;
    logic [2:0]                     rel_idx;

    assign accept  = i_push & ~i_q_full;
    assign rel_idx = 3'(r_count - 4'd1);

    always_comb begin
        n_count         = r_count;
        n_crc           = r_crc;
        n_staged_relays = r_staged_relays;
        n_staged_volume = r_staged_volume;
        if (accept) begin
            if (i_last_byte) begin
                n_count = '0;
                n_crc   = crcfr_pkg::CRC_INIT;
            end else begin
                n_crc = crcfr_pkg::crc8_byte(r_crc, i_byte_value);
                if (r_count >= 4'd1 && r_count <= RELAY_LAST) begin
                    n_staged_relays[rel_idx] = (i_byte_value != '0);
                end else if (r_count == VOL_LO_POS) begin
                    n_staged_volume[7:0] = i_byte_value;
                end else if (r_count == VOL_HI_POS) begin
                    n_staged_volume[15:8] = i_byte_value;
                end
                if (r_count != crcfr_pkg::COUNT_MAX) begin
                    n_count = r_count + 4'd1;
                end
            end
        end
    end

    always_comb begin
        o_rec_push    = accept & i_last_byte;
        o_rec.relays  = r_staged_relays & RELAY_MASK;
        o_rec.volume  = r_staged_volume;
        priority if (r_count != LEN_OK) begin
            o_rec.status = crcfr_pkg::ST_BAD_LEN;
        end else if (r_crc != i_byte_value) begin
            o_rec.status = crcfr_pkg::ST_BAD_CRC;
        end else begin
            o_rec.status = crcfr_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_crc           <= crcfr_pkg::CRC_INIT;
            r_staged_relays <= '0;
            r_staged_volume <= '0;
        end else begin
            r_count         <= n_count;
            r_crc           <= n_crc;
            r_staged_relays <= n_staged_relays;
            r_staged_volume <= n_staged_volume;
        end
    end

endmodule

// ===== hw/rtl/crcfr_queue.sv =====
module crcfr_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  crcfr_pkg::t_frame_rec   i_rec,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_empty,
    output crcfr_pkg::t_frame_rec   o_rec
);

    crcfr_pkg::t_frame_rec r_mem [2];
    logic                  r_wr_ptr, n_wr_ptr;
    logic                  r_rd_ptr, n_rd_ptr;
    logic [1:0]            r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/crcfr_back.sv =====
module crcfr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rec_valid,
    input  crcfr_pkg::t_frame_rec               i_rec,
    output logic                                o_rec_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [1:0]                          o_status,
    output logic [crcfr_pkg::RELAY_W-1:0]       o_relay_levels,
    output logic [crcfr_pkg::RELAY_W-1:0]       o_relay_changed,
    output logic [crcfr_pkg::VOLUME_W-1:0]      o_volume,
    output logic                                o_volume_changed
);

    logic [crcfr_pkg::RELAY_W-1:0]  r_relay_state, n_relay_state;
    logic [crcfr_pkg::VOLUME_W-1:0] r_volume_state, n_volume_state;
    logic                           r_out_valid, n_out_valid;
    crcfr_pkg::t_status             r_out_status, n_out_status;
    logic [crcfr_pkg::RELAY_W-1:0]  r_out_changed, n_out_changed;
    logic                           r_out_vchg, n_out_vchg;
    logic                           take;

    assign take      = i_rec_valid & (~r_out_valid | i_pop);
    assign o_rec_pop = take;

    always_comb begin
        n_relay_state  = r_relay_state;
        n_volume_state = r_volume_state;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_changed  = r_out_changed;
        n_out_vchg     = r_out_vchg;
        if (take) begin
            n_out_valid   = 1'b1;
            n_out_status  = i_rec.status;
            n_out_changed = '0;
            n_out_vchg    = 1'b0;
            if (i_rec.status == crcfr_pkg::ST_OK) begin
                n_out_changed  = i_rec.relays ^ r_relay_state;
                n_out_vchg     = (i_rec.volume != r_volume_state);
                n_relay_state  = i_rec.relays;
                n_volume_state = i_rec.volume;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_state  <= '0;
            r_volume_state <= '0;
            r_out_valid    <= 1'b0;
            r_out_status   <= crcfr_pkg::ST_OK;
            r_out_changed  <= '0;
            r_out_vchg     <= 1'b0;
        end else begin
            r_relay_state  <= n_relay_state;
            r_volume_state <= n_volume_state;
            r_out_valid    <= n_out_valid;
            r_out_status   <= n_out_status;
            r_out_changed  <= n_out_changed;
            r_out_vchg     <= n_out_vchg;
        end
    end

    assign o_empty          = ~r_out_valid;
    assign o_status         = r_out_status;
    assign o_relay_levels   = r_relay_state;
    assign o_relay_changed  = r_out_changed;
    assign o_volume         = r_volume_state;
    assign o_volume_changed = r_out_vchg;

endmodule

// ===== hw/rtl/crc_checked_control_frame_receiver.sv =====
// Control frame receiver with CRC-8 check (poly 0x31, init 0xFF, MSB first).
// Input channel: one byte per transaction, i_push while o_full is low; i_last_byte
// marks the CRC byte that closes a frame of FRAME_BYTES data bytes.
// Result channel: one result per frame, shown while o_empty is low, taken by i_pop.
// Each result carries status (ok, bad length, bad CRC), the relay levels and
// volume in force, and the change mask and volume-changed flag of that frame.
// Throughput: one byte per cycle, sustained while o_full is low; the front end
// folds each byte into the CRC combinationally.
// A frame's result is written into the two-entry frame queue when its last byte
// is accepted, then moves into the result register, from which it shows, once
// that register is free.
// If the receiver stalls, up to two closed frames wait in the queue plus one in
// the result register; o_full then rises and holds off further bytes.
// Reset (synchronous, i_rst_n low) clears the byte count, reloads the CRC with
// 0xFF, zeroes relay and volume state and empties the queue and result register.
module crc_checked_control_frame_receiver #(
    parameter int FRAME_BYTES = 10,
    parameter int RELAY_COUNT = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [crcfr_pkg::BYTE_W-1:0]        i_byte_value,
    input  logic                                i_last_byte,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [1:0]                          o_status,
    output logic [crcfr_pkg::RELAY_W-1:0]       o_relay_levels,
    output logic [crcfr_pkg::RELAY_W-1:0]       o_relay_changed,
    output logic [crcfr_pkg::VOLUME_W-1:0]      o_volume,
    output logic                                o_volume_changed
);

    crcfr_pkg::t_frame_rec front_rec;
    crcfr_pkg::t_frame_rec q_rec;
    logic                  front_push;
    logic                  q_full;
    logic                  q_empty;
    logic                  back_pop;

    assign o_full = q_full;

    crcfr_front #(
        .FRAME_BYTES (FRAME_BYTES),
        .RELAY_COUNT (RELAY_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_q_full     (q_full),
        .o_rec_push   (front_push),
        .o_rec        (front_rec)
    );

    crcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    crcfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rec_valid      (~q_empty),
        .i_rec            (q_rec),
        .o_rec_pop        (back_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_status         (o_status),
        .o_relay_levels   (o_relay_levels),
        .o_relay_changed  (o_relay_changed),
        .o_volume         (o_volume),
        .o_volume_changed (o_volume_changed)
    );

endmodule

// ===== hw/rtl/crcfr_checker.sv =====
module crcfr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_push,
    input logic                                 o_full,
    input logic [crcfr_pkg::BYTE_W-1:0]         i_byte_value,
    input logic                                 i_last_byte,
    input logic                                 o_empty,
    input logic                                 i_pop,
    input logic [1:0]                           o_status,
    input logic [crcfr_pkg::RELAY_W-1:0]        o_relay_levels,
    input logic [crcfr_pkg::RELAY_W-1:0]        o_relay_changed,
    input logic [crcfr_pkg::VOLUME_W-1:0]       o_volume,
    input logic                                 o_volume_changed
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result channel not empty after reset");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status == crcfr_pkg::ST_OK || o_status == crcfr_pkg::ST_BAD_LEN ||
                      o_status == crcfr_pkg::ST_BAD_CRC))
        else $error("illegal status code");

    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != crcfr_pkg::ST_OK) |->
            (o_relay_changed == '0 && !o_volume_changed))
        else $error("failed frame reports a change");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_status) && $stable(o_relay_levels) &&
             $stable(o_relay_changed) && $stable(o_volume) && $stable(o_volume_changed)))
        else $error("stalled result changed");

endmodule

bind crc_checked_control_frame_receiver crcfr_checker u_checker (.*);

// ===== tb/crcfr_tb_pkg.sv =====
package crcfr_tb_pkg;

    import crcfr_pkg::*;

    // Fold one byte into a CRC-8, one bit at a time, MSB first.
    function automatic logic [BYTE_W-1:0] crc8_fold(
        input logic [BYTE_W-1:0] acc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] r;
        logic              fb;
        r = acc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = r[BYTE_W-1] ^ data[i];
            r  = {r[BYTE_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ===== tb/crcfr_frame_checker.sv =====
module crcfr_frame_checker
    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;
#(
    parameter int FRAME_BYTES = 10,
    parameter int RELAY_COUNT = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [BYTE_W-1:0]   i_byte_value,
    input  logic                i_last_byte,
    input  logic                i_empty,
    input  logic                i_pop,
    input  logic [1:0]          i_status,
    input  logic [RELAY_W-1:0]  i_relay_levels,
    input  logic [RELAY_W-1:0]  i_relay_changed,
    input  logic [VOLUME_W-1:0] i_volume,
    input  logic                i_volume_changed,
    output int                  o_fail_count,
    output int                  o_waiting,
    output int                  o_checked
);

    localparam logic [RELAY_W-1:0] RELAY_MASK = RELAY_W'((1 << RELAY_COUNT) - 1);

    typedef struct {
        t_status             status;
        logic [RELAY_W-1:0]  levels;
        logic [RELAY_W-1:0]  changed;
        logic [VOLUME_W-1:0] volume;
        logic                vol_changed;
    } t_frame_verdict;

    t_frame_verdict       verdict_q[$];
    logic [COUNT_W-1:0]   byte_pos;
    logic [BYTE_W-1:0]    crc_acc;
    logic [RELAY_W-1:0]   staged_relays;
    logic [VOLUME_W-1:0]  staged_volume;
    logic [RELAY_W-1:0]   relays_now;
    logic [VOLUME_W-1:0]  volume_now;
    int                   fails;
    int                   checked;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_verdict want;
        t_frame_verdict nv;
        if (!i_rst_n) begin
            verdict_q.delete();
            byte_pos      = '0;
            crc_acc       = CRC_INIT;
            staged_relays = '0;
            staged_volume = '0;
            relays_now    = '0;
            volume_now    = '0;
            fails         = 0;
            checked       = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (verdict_q.size() == 0) begin
                    $error("result transaction with no frame waiting: status %0d", i_status);
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("relay_levels", want.levels, i_relay_levels);
                    check_field("relay_changed", want.changed, i_relay_changed);
                    check_field("volume", want.volume, i_volume);
                    check_field("volume_changed", want.vol_changed, i_volume_changed);
                    checked++;
                end
            end
            if (i_push && !i_full) begin
                if (!i_last_byte) begin
                    crc_acc = crc8_fold(crc_acc, i_byte_value);
                    if (byte_pos >= 1 && byte_pos <= RELAY_COUNT) begin
                        staged_relays[byte_pos-1] = (i_byte_value != '0);
                    end else if (byte_pos == RELAY_COUNT + 1) begin
                        staged_volume[7:0] = i_byte_value;
                    end else if (byte_pos == RELAY_COUNT + 2) begin
                        staged_volume[15:8] = i_byte_value;
                    end
                    if (byte_pos != COUNT_MAX) begin
                        byte_pos++;
                    end
                end else begin
                    nv.changed     = '0;
                    nv.vol_changed = 1'b0;
                    if (byte_pos != FRAME_BYTES) begin
                        nv.status = ST_BAD_LEN;
                    end else if (crc_acc != i_byte_value) begin
                        nv.status = ST_BAD_CRC;
                    end else begin
                        nv.status      = ST_OK;
                        nv.changed     = (staged_relays ^ relays_now) & RELAY_MASK;
                        nv.vol_changed = (staged_volume != volume_now);
                        relays_now     = staged_relays & RELAY_MASK;
                        volume_now     = staged_volume;
                    end
                    nv.levels = relays_now;
                    nv.volume = volume_now;
                    verdict_q.push_back(nv);
                    byte_pos = '0;
                    crc_acc  = CRC_INIT;
                end
            end
        end
        o_fail_count <= fails;
        o_waiting    <= verdict_q.size();
        o_checked    <= checked;
    end

endmodule

// ===== tb/crc_checked_control_frame_receiver_tb.sv =====
module crc_checked_control_frame_receiver_tb;

    import crcfr_pkg::*;
    import crcfr_tb_pkg::*;

    localparam int FRAME_BYTES = 10;
    localparam int RELAY_COUNT = 6;
    localparam int N_BYTES     = 650;
    localparam int IDLE_PCT    = 19;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_push       = 1'b0;
    logic [BYTE_W-1:0]   i_byte_value = '0;
    logic                i_last_byte  = 1'b0;
    logic                i_pop        = 1'b0;
    logic                o_full;
    logic                o_empty;
    logic [1:0]          o_status;
    logic [RELAY_W-1:0]  o_relay_levels;
    logic [RELAY_W-1:0]  o_relay_changed;
    logic [VOLUME_W-1:0] o_volume;
    logic                o_volume_changed;

    int fail_count;
    int waiting;
    int checked;

    bit                       calm;
    int                       bytes_sent;
    int                       n_frames;
    int                       n_good;
    int                       n_bad_crc;
    int                       n_bad_len;
    int                       n_junk;
    int                       pick;
    int                       len;
    int                       idx;
    logic [BYTE_W-1:0]        frame_body[$];
    logic [FRAME_BYTES*8-1:0] good_body;
    logic [FRAME_BYTES*8-1:0] body;

    crc_checked_control_frame_receiver #(
        .FRAME_BYTES(FRAME_BYTES),
        .RELAY_COUNT(RELAY_COUNT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_byte_value    (i_byte_value),
        .i_last_byte     (i_last_byte),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_status        (o_status),
        .o_relay_levels  (o_relay_levels),
        .o_relay_changed (o_relay_changed),
        .o_volume        (o_volume),
        .o_volume_changed(o_volume_changed)
    );

    crcfr_frame_checker #(
        .FRAME_BYTES(FRAME_BYTES),
        .RELAY_COUNT(RELAY_COUNT)
    ) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_full          (o_full),
        .i_byte_value    (i_byte_value),
        .i_last_byte     (i_last_byte),
        .i_empty         (o_empty),
        .i_pop           (i_pop),
        .i_status        (o_status),
        .i_relay_levels  (o_relay_levels),
        .i_relay_changed (o_relay_changed),
        .i_volume        (o_volume),
        .i_volume_changed(o_volume_changed),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting),
        .o_checked       (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (o_full) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic load_body(input logic [FRAME_BYTES*8-1:0] v);
        frame_body.delete();
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_body.push_back(v[(FRAME_BYTES-1-i)*8 +: 8]);
        end
    endtask

    // Send the staged bytes, then the CRC over them with the given bits flipped.
    task automatic push_frame(input logic [BYTE_W-1:0] crc_flip);
        logic [BYTE_W-1:0] c;
        c = CRC_INIT;
        foreach (frame_body[i]) begin
            c = crc8_fold(c, frame_body[i]);
            push_byte(frame_body[i], 1'b0);
        end
        push_byte(c ^ crc_flip, 1'b1);
        n_frames++;
    endtask

    // Repeat, tweak or replace the last good frame so that unchanged fields occur.
    task automatic make_body();
        pick = $urandom_range(9);
        body = good_body;
        if (pick >= 1 && pick <= 3) begin
            repeat ($urandom_range(2, 1)) begin
                idx = $urandom_range(FRAME_BYTES - 1);
                body[idx*8 +: 8] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
            end
        end else if (pick > 3) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (i >= 1 && i <= RELAY_COUNT && $urandom_range(1) == 0) begin
                    body[(FRAME_BYTES-1-i)*8 +: 8] = 8'h00;
                end else begin
                    body[(FRAME_BYTES-1-i)*8 +: 8] = 8'($urandom_range(255));
                end
            end
        end
        load_body(body);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all relays on through assorted nonzero bytes, full-scale volume
        load_body({8'hFF, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'hFE, 8'hFF, 8'hFF, 8'hFF});
        push_frame(8'h00);
        n_good++;
        push_byte(8'h00, 1'b1);
        n_junk++;
        good_body = '0;
        load_body(good_body);
        push_frame(8'h00);
        n_good++;

        while (bytes_sent < N_BYTES) begin
            calm = (n_frames >= 20 && n_frames < 34);
            make_body();
            pick = $urandom_range(99);
            if (pick < 70) begin
                push_frame(8'h00);
                good_body = body;
                n_good++;
            end else if (pick < 80) begin
                push_frame(8'($urandom_range(255, 1)));
                n_bad_crc++;
            end else if (pick < 92) begin
                len = $urandom_range(19);
                if (len >= FRAME_BYTES) begin
                    len++;
                end
                while (frame_body.size() > len) begin
                    void'(frame_body.pop_back());
                end
                while (frame_body.size() < len) begin
                    frame_body.push_back(8'($urandom_range(255)));
                end
                push_frame($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
                n_bad_len++;
            end else begin
                repeat ($urandom_range(3)) begin
                    push_byte(8'($urandom_range(255)), 1'b0);
                end
                push_byte(8'($urandom_range(255)), 1'b1);
                n_junk++;
            end
        end
        calm = 1'b0;
        i_push <= 1'b0;

        @(posedge i_clk);
        while (waiting != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes: %0d good frames, %0d bad-CRC, %0d bad-length, %0d junk writes",
                 bytes_sent, n_good, n_bad_crc, n_bad_len, n_junk);
        $display("Checked %0d result transactions, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_front.sv
hw/rtl/crcfr_queue.sv
hw/rtl/crcfr_back.sv
hw/rtl/crc_checked_control_frame_receiver.sv
hw/rtl/crcfr_checker.sv
tb/crcfr_tb_pkg.sv
tb/crcfr_frame_checker.sv
tb/crc_checked_control_frame_receiver_tb.sv
